FILE: hw/rtl/tile_cache_lru_tag_controller_top_assert.svh
// assertion macros for the tile cache tag controller
// used by the top level only, no other dependencies
`ifndef TILE_CACHE_LRU_TAG_CONTROLLER_TOP_ASSERT_SVH
`define TILE_CACHE_LRU_TAG_CONTROLLER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define TC_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define TC_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define TC_ASSERT_IMP(label, clk, rst_n, a, c)
`define TC_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: hw/rtl/tclru_pkg.sv
// shared types and constants for the tile cache tag controller
// no dependencies
package tclru_pkg;
  localparam int SLOTS = 8;
  localparam int SW = $clog2(SLOTS);
  localparam int MASK_BITS = 8;
  localparam int KEY_W = 49;
  localparam logic [1:0] REQ_LOOKUP  = 2'd0;
  localparam logic [1:0] REQ_INSERT  = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;
  localparam logic [0:0] CFG_LEN  = 1'd0;
  localparam logic [0:0] CFG_MASK = 1'd1;
  localparam int QDEPTH = 2;

  // classified request carried from front to back
  typedef struct packed {
    logic [1:0]       kind;
    logic             bad;
    logic [KEY_W-1:0] key;
  } req_t;
endpackage

FILE: hw/rtl/tclru_front.sv
// front part: accepts requests, checks length and buffer, packs the key
// depends on tclru_pkg
module tclru_front import tclru_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic [16:0] exp_len,
  output logic        q_valid,
  input  logic        q_ready,
  output req_t        q_data
);
  req_t       cls;
  logic [19:0] len;
  logic        buf_p;
  req_t        q_r [QDEPTH];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        rd_r, rd_nxt, wr_r, wr_nxt;
  logic        push, pop;

  // classify the incoming transfer
  always_comb begin
    len   = in_tdata[68:49];
    buf_p = in_tdata[69];
    cls.kind = in_tuser;
    cls.key  = {in_tdata[4:0], in_tdata[26:5], in_tdata[48:27]};
    cls.bad  = (in_tuser == REQ_UNKNOWN) ||
               ((in_tuser != REQ_CLEAR) && (!buf_p || len != {3'd0, exp_len}));
  end

  assign in_tready = (cnt_r != 2'(QDEPTH));
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_data = q_r[rd_r];

  // two-entry queue toward the back part
  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
    wr_nxt = push ? ~wr_r : wr_r;
    rd_nxt = pop ? ~rd_r : rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; rd_r <= rd_nxt; wr_r <= wr_nxt;
    end
    if (push) q_r[wr_r] <= cls;
  end
endmodule

FILE: hw/rtl/tclru_back.sv
// back part: tag compare, victim choice, age update, result register
// depends on tclru_pkg
module tclru_back import tclru_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  req_t        q_data,
  input  logic        cfg_mask_we,
  input  logic [7:0]  cfg_mask,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic [1:0]  out_tuser
);
  typedef enum logic [1:0] {S_CMP = 2'b01, S_UPD = 2'b10} state_t;
  state_t state_r, state_nxt;
  logic [KEY_W-1:0] key_r [SLOTS];
  logic [SLOTS-1:0] val_r;
  logic [SW-1:0]    age_r [SLOTS];
  logic [7:0]       mask_r;
  logic [SLOTS-1:0] att, live;
  req_t             req_r;
  logic             hit_r, tgt_ok_r;
  logic [SW-1:0]    tgt_r;
  logic             hit_c, inv_c, best_c;
  logic [SW-1:0]    hidx, iidx, bidx;
  logic [SW:0]      old;
  logic [1:0]       st_c;
  logic [SW:0]      cnt;
  logic             ov_r;
  logic [1:0]       ost_r;
  logic [SW-1:0]    oslot_r;
  logic             ohit_r;
  logic [3:0]       ocnt_r;
  logic [SLOTS-1:0] val_nxt;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      att[i] = (i < MASK_BITS) ? mask_r[i % MASK_BITS] : 1'b0;
      live[i] = att[i] && val_r[i];
    end
  end

  // parallel tag match against the queue head, first invalid and oldest slot
  always_comb begin
    hit_c = 1'b0; hidx = '0; inv_c = 1'b0; iidx = '0; best_c = 1'b0; bidx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (live[i] && key_r[i] == q_data.key) begin hit_c = 1'b1; hidx = SW'(i); end
      if (att[i] && !val_r[i]) begin inv_c = 1'b1; iidx = SW'(i); end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (live[i] && (!best_c || age_r[i] > age_r[bidx])) begin
        best_c = 1'b1; bidx = SW'(i);
      end
    end
  end

  assign q_ready = (state_r == S_CMP) && !ov_r && !cfg_mask_we;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CMP:   if (q_valid && q_ready) state_nxt = S_UPD;
      S_UPD:   state_nxt = S_CMP;
      default: state_nxt = S_CMP;
    endcase
  end

  // status of the held request
  always_comb begin
    st_c = ST_OK;
    if (req_r.kind == REQ_CLEAR) st_c = ST_OK;
    else if (req_r.bad) st_c = ST_BAD;
    else if (req_r.kind == REQ_LOOKUP) st_c = hit_r ? ST_OK : ST_MISS;
    else st_c = tgt_ok_r ? ST_OK : ST_FULL;
    old = val_r[tgt_r] ? {1'b0, age_r[tgt_r]} : (SW+1)'(SLOTS);
    val_nxt = val_r;
    if (req_r.kind == REQ_CLEAR && !req_r.bad) val_nxt = '0;
    else if (st_c == ST_OK && req_r.kind == REQ_INSERT) val_nxt[tgt_r] = 1'b1;
    cnt = '0;
    for (int i = 0; i < SLOTS; i++) cnt = cnt + (SW+1)'(att[i] && val_nxt[i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CMP; val_r <= '0; mask_r <= '0; ov_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) age_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_tvalid && out_tready) ov_r <= 1'b0;
      if (cfg_mask_we) begin
        mask_r <= cfg_mask;
        for (int i = 0; i < SLOTS; i++)
          if (i < MASK_BITS && cfg_mask[i % MASK_BITS]) begin
            val_r[i] <= 1'b0; age_r[i] <= '0;
          end
      end
      // commit the request and load the result
      if (state_r == S_UPD) begin
        ov_r <= 1'b1;
        val_r <= val_nxt;
        if (req_r.kind == REQ_CLEAR && !req_r.bad) begin
          for (int i = 0; i < SLOTS; i++) age_r[i] <= '0;
        end else if (st_c == ST_OK) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (SW'(i) == tgt_r) age_r[i] <= '0;
            else if (live[i] && {1'b0, age_r[i]} < old && age_r[i] != SW'(SLOTS - 1))
              age_r[i] <= age_r[i] + 1'b1;
          end
        end
      end
    end
    if (q_valid && q_ready) req_r <= q_data;
    if (state_r == S_CMP) begin
      hit_r <= hit_c;
      tgt_ok_r <= hit_c || inv_c || best_c;
      tgt_r <= hit_c ? hidx : (inv_c ? iidx : bidx);
    end
    if (state_r == S_UPD) begin
      if (st_c == ST_OK && req_r.kind == REQ_INSERT) key_r[tgt_r] <= req_r.key;
      ost_r <= st_c;
      oslot_r <= (st_c == ST_OK && req_r.kind != REQ_CLEAR) ? tgt_r : '0;
      ohit_r <= (st_c == ST_OK && req_r.kind != REQ_CLEAR) ? hit_r : 1'b0;
      ocnt_r <= 4'(cnt);
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser = ost_r;
  assign out_tdata = {8'd0, ocnt_r, ohit_r, 3'(oslot_r)};
endmodule

FILE: hw/rtl/tile_cache_lru_tag_controller_top.sv
// tile cache tag controller: one result per request
// a request passes the two-entry queue, the compare step and the update step into the result
// register; a new request is taken only once the result is taken and no mask write is pending
// a two-entry queue parts front from back; result register holds until taken
// rst_n synchronous active low: all slots invalid, age 0, mask 0, length 65536
module tile_cache_lru_tag_controller_top import tclru_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // key_zoom, key_x, key_y, request_length, buffer_present
  input  logic [1:0]  in_tuser,  // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // slot, hit, valid_count
  output logic [1:0]  out_tuser, // status
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_wdata
);
`include "tile_cache_lru_tag_controller_top_assert.svh"
  logic [16:0] len_r;
  logic        q_valid, q_ready;
  req_t        q_data;
  logic        mask_we;

  // length register
  always_ff @(posedge clk) begin
    if (!rst_n) len_r <= 17'd65536;
    else if (cfg_we && cfg_index == CFG_LEN) len_r <= cfg_wdata;
  end
  assign mask_we = cfg_we && cfg_index == CFG_MASK;

  tclru_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .exp_len(len_r), .q_valid, .q_ready, .q_data
  );

  tclru_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .cfg_mask_we(mask_we), .cfg_mask(cfg_wdata[7:0]),
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  `TC_ASSERT_IMP(a_cnt_range, clk, rst_n, out_tvalid, out_tdata[7:4] <= 4'd8)
  `TC_ASSERT_IMP(a_bad_nohit, clk, rst_n, out_tvalid && out_tuser != ST_OK,
                 out_tdata[3] == 1'b0)
  `TC_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                 out_tvalid && $stable(out_tdata))
endmodule
